[src/cmmq_pkg.sv]
// Shared types and constants for the counting min/max queue.
// No dependencies; imported by the count RAM and the top level.
package cmmq_pkg;

    // Width of the key and removed_key ports.
    localparam int KEY_BITS = 14;

    typedef enum logic
    {
        ACT_ADD    = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef enum logic
    {
        POLICY_SMALLEST = 1'b0,
        POLICY_LARGEST  = 1'b1
    } policy_t;

endpackage

[src/cmmq_count_ram.sv]
// Count store of the counting min/max queue: one write port, one read port,
// registered read data. No reset on the array. Depends on cmmq_pkg.
module cmmq_count_ram #(
    parameter int DEPTH     = 16384,
    parameter int ADDR_BITS = 14,
    parameter int DATA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);
    import cmmq_pkg::*;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/counting_min_max_queue.sv]
// Counting min/max queue: one saturating count per key in a RAM of KEY_RANGE
// words, with low and high scan bounds. Adds bump a count; removes scan the
// RAM from one bound toward the other. After reset the block sweeps the RAM
// to zero and holds in_stall high meanwhile (cfg writes are still taken). An
// add passes through accept, RAM read and RAM write. A remove is accepted,
// then scans the count entries: the single RAM read port checks one entry per
// cycle, starting at the bound chosen by take_largest. A remove that gives a
// word then loads the output register, waiting while an earlier word is still
// stalled there. An empty remove with crossed bounds skips the scan and goes
// straight to the result. A finished word waits in the output register while
// the next item is accepted. Depends on cmmq_pkg and cmmq_count_ram.
module counting_min_max_queue #(
    parameter int KEY_RANGE  = 16384,
    parameter int COUNT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [cmmq_pkg::KEY_BITS-1:0]  key,
    input  logic                           report,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cmmq_pkg::KEY_BITS-1:0]  removed_key,
    output logic                           empty_res
);
    import cmmq_pkg::*;

    localparam int IDX_BITS = $clog2(KEY_RANGE);
    localparam int CMP_BITS = ((IDX_BITS > KEY_BITS) ? IDX_BITS : KEY_BITS) + 1;
    localparam logic [IDX_BITS-1:0]   IDX_LAST  = IDX_BITS'(KEY_RANGE - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_ADD_WR,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t                state_reg, state_next;
    logic                  take_largest_reg, take_largest_next;
    logic [IDX_BITS-1:0]   low_reg, low_next;
    logic [IDX_BITS-1:0]   high_reg, high_next;
    logic [IDX_BITS-1:0]   ptr_reg, ptr_next;
    logic                  action_reg, action_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic                  report_reg, report_next;
    logic [KEY_BITS-1:0]   res_key_reg, res_key_next;
    logic                  res_empty_reg, res_empty_next;
    logic                  out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0]   out_key_reg, out_key_next;
    logic                  out_empty_reg, out_empty_next;

    logic                  ram_wr_en;
    logic [IDX_BITS-1:0]   ram_wr_addr;
    logic [COUNT_BITS-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [IDX_BITS-1:0]   ram_rd_addr;
    logic [COUNT_BITS-1:0] ram_rd_data;

    logic                  key_in_range;
    logic [IDX_BITS-1:0]   key_idx;
    logic                  largest;
    logic [IDX_BITS-1:0]   scan_start;
    logic [IDX_BITS-1:0]   scan_end;
    logic                  at_end;
    logic [IDX_BITS-1:0]   ptr_step;

    cmmq_count_ram #(
        .DEPTH     (KEY_RANGE),
        .ADDR_BITS (IDX_BITS),
        .DATA_BITS (COUNT_BITS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign key_in_range = CMP_BITS'(key_reg) < CMP_BITS'(KEY_RANGE);
    assign key_idx      = IDX_BITS'(key_reg);
    assign largest      = (take_largest_reg == POLICY_LARGEST);
    assign scan_start   = largest ? high_reg : low_reg;
    assign scan_end     = largest ? low_reg : high_reg;
    assign at_end       = (ptr_reg == scan_end);
    assign ptr_step     = largest ? (ptr_reg - IDX_BITS'(1)) : (ptr_reg + IDX_BITS'(1));

    always_comb
    begin
        state_next        = state_reg;
        take_largest_next = take_largest_reg;
        low_next          = low_reg;
        high_next         = high_reg;
        ptr_next          = ptr_reg;
        action_next       = action_reg;
        key_next          = key_reg;
        report_next       = report_reg;
        res_key_next      = res_key_reg;
        res_empty_next    = res_empty_reg;
        out_valid_next    = out_valid_reg;
        out_key_next      = out_key_reg;
        out_empty_next    = out_empty_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = ptr_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ptr_reg;

        if (cfg_write)
        begin
            take_largest_next = cfg_data;
        end

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
                ptr_next  = ptr_reg + IDX_BITS'(1);
                if (ptr_reg == IDX_LAST)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = action;
                    key_next    = key;
                    report_next = report;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                if (action_reg == ACT_ADD)
                begin
                    if (key_in_range)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = key_idx;
                        if (key_idx < low_reg)
                        begin
                            low_next = key_idx;
                        end
                        if (key_idx > high_reg)
                        begin
                            high_next = key_idx;
                        end
                        state_next = ST_ADD_WR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (low_reg > high_reg)
                begin
                    res_key_next   = '0;
                    res_empty_next = 1'b1;
                    state_next     = ST_RESULT;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = scan_start;
                    ptr_next    = scan_start;
                    state_next  = ST_SCAN;
                end
            end
            ST_ADD_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = key_idx;
                ram_wr_data = (ram_rd_data == COUNT_MAX) ? ram_rd_data
                                                         : ram_rd_data + COUNT_BITS'(1);
                state_next  = ST_IDLE;
            end
            ST_SCAN:
            begin
                // read data is ptr_reg's; a zero entry before scan_end fetches next
                if (ram_rd_data != '0)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data - COUNT_BITS'(1);
                    if (largest)
                    begin
                        high_next = ptr_reg;
                    end
                    else
                    begin
                        low_next = ptr_reg;
                    end
                    if (report_reg)
                    begin
                        res_key_next   = KEY_BITS'(ptr_reg);
                        res_empty_next = 1'b0;
                        state_next     = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (at_end)
                begin
                    res_key_next   = '0;
                    res_empty_next = 1'b1;
                    state_next     = ST_RESULT;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_step;
                    ptr_next    = ptr_step;
                end
            end
            ST_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = res_key_reg;
                    out_empty_next = res_empty_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            take_largest_reg <= POLICY_SMALLEST;
            low_reg          <= IDX_LAST;
            high_reg         <= '0;
            ptr_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            take_largest_reg <= take_largest_next;
            low_reg          <= low_next;
            high_reg         <= high_next;
            ptr_reg          <= ptr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        key_reg       <= key_next;
        report_reg    <= report_next;
        res_key_reg   <= res_key_next;
        res_empty_reg <= res_empty_next;
        out_key_reg   <= out_key_next;
        out_empty_reg <= out_empty_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign removed_key = out_key_reg;
    assign empty_res   = out_empty_reg;

endmodule

[tb/sv/tb_counting_min_max_queue.sv]
// Self-checking testbench for counting_min_max_queue: directed, random and repeated-key tests
// against a built-in predictor of the per-key counts and the two scan bounds.
// Depends on cmmq_pkg and the counting_min_max_queue RTL.
`timescale 1ns / 100ps

module tb_counting_min_max_queue;
    import cmmq_pkg::*;

    localparam int NUM_KEYS = 16384;
    localparam int COUNT_BITS = 16;
    localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
    localparam int ROUNDS = 8;
    localparam int ITEMS_PER_ROUND = 90;
    localparam int REPEAT_DEPTH = 24;
    // Clearing pass plus one full-range scan, with room for output stalls, four times over.
    localparam int QUIET_LIMIT = 4 * (2 * NUM_KEYS + 64);

    typedef struct packed
    {
        logic [KEY_BITS-1:0] key_out;
        logic                empty_flag;
    } removal_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic                cfg_data = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                action = ACT_ADD;
    logic [KEY_BITS-1:0] key = '0;
    logic                report = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [KEY_BITS-1:0] removed_key;
    logic                empty_res;

    // Predictor state
    bit [COUNT_BITS-1:0] key_tally [NUM_KEYS];
    int                  lo_key;
    int                  hi_key;
    policy_t             policy_now;
    int                  held_total;
    int                  busy_cycles;
    removal_t            removals_due[$];

    bit in_gaps_on = 1'b1;
    bit out_gaps_on = 1'b1;
    int mismatch_count = 0;
    int results_checked = 0;
    int adds_sent = 0;
    int removes_sent = 0;
    int empties_seen = 0;
    int quiet_cycles = 0;

    counting_min_max_queue #(
        .KEY_RANGE  (NUM_KEYS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key         (key),
        .report      (report),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .removed_key (removed_key),
        .empty_res   (empty_res)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic queue_reset();
        int idx;
        for (idx = 0; idx < NUM_KEYS; idx++)
            key_tally[idx] = '0;
        lo_key = NUM_KEYS - 1;
        hi_key = 0;
        policy_now = POLICY_SMALLEST;
        held_total = 0;
        busy_cycles = NUM_KEYS;
    endtask

    // Apply one accepted word to the predicted queue and queue up its result, if any.
    task automatic apply_word(action_t act, bit [KEY_BITS-1:0] k, bit rep);
        int idx;
        int steps;
        int at;
        bit hit;
        steps = 0;
        at = 0;
        hit = 1'b0;
        if (act == ACT_ADD)
        begin
            adds_sent++;
            busy_cycles = 3;
            if (key_tally[k] != COUNT_MAX[COUNT_BITS-1:0])
            begin
                key_tally[k]++;
                held_total++;
            end
            // Bounds widen even when the count is already pinned.
            if (int'(k) < lo_key)
                lo_key = int'(k);
            if (int'(k) > hi_key)
                hi_key = int'(k);
            return;
        end
        removes_sent++;
        if (lo_key <= hi_key)
        begin
            if (policy_now == POLICY_LARGEST)
            begin
                for (idx = hi_key; idx >= lo_key && !hit; idx--)
                begin
                    steps++;
                    if (key_tally[idx] != 0)
                    begin
                        hit = 1'b1;
                        at = idx;
                    end
                end
            end
            else
            begin
                for (idx = lo_key; idx <= hi_key && !hit; idx++)
                begin
                    steps++;
                    if (key_tally[idx] != 0)
                    begin
                        hit = 1'b1;
                        at = idx;
                    end
                end
            end
        end
        busy_cycles = 3 + steps;
        if (!hit)
        begin
            // Empty: always one result, bounds untouched.
            removals_due.push_back('{key_out: '0, empty_flag: 1'b1});
            return;
        end
        key_tally[at]--;
        held_total--;
        if (policy_now == POLICY_LARGEST)
            hi_key = at;
        else
            lo_key = at;
        if (rep)
            removals_due.push_back('{key_out: at[KEY_BITS-1:0], empty_flag: 1'b0});
    endtask

    // Drive one word at a falling edge and hold it until the block takes it.
    task automatic send_word(action_t act, logic [KEY_BITS-1:0] k, logic rep);
        if (in_gaps_on && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 28);
        end
        in_valid <= 1'b1;
        action <= act;
        key <= k;
        report <= rep;
        do
            @(posedge clk);
        while (in_stall);
        apply_word(act, k, rep);
        @(negedge clk);
    endtask

    // Hold the sender until every result is in and the last word has had time to finish.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (removals_due.size() != 0)
            @(negedge clk);
        repeat (busy_cycles + 4)
            @(negedge clk);
    endtask

    task automatic set_policy(policy_t p);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_data <= p;
        @(negedge clk);
        cfg_write <= 1'b0;
        policy_now = p;
    endtask

    task automatic drain_queue();
        while (held_total > 0)
            send_word(ACT_REMOVE, KEY_BITS'($urandom_range(0, NUM_KEYS - 1)),
                      1'($urandom_range(1)));
    endtask

    // On an empty queue, pull both bounds onto one key so later scans stay short.
    task automatic narrow_bounds(int k);
        set_policy(POLICY_SMALLEST);
        send_word(ACT_ADD, KEY_BITS'(k), 1'b0);
        send_word(ACT_REMOVE, KEY_BITS'($urandom_range(0, NUM_KEYS - 1)), 1'b1);
        set_policy(POLICY_LARGEST);
        send_word(ACT_ADD, KEY_BITS'(k), 1'b0);
        send_word(ACT_REMOVE, KEY_BITS'($urandom_range(0, NUM_KEYS - 1)), 1'b1);
    endtask

    task automatic test_empty_at_reset();
        // Bounds are crossed right after reset; report must not matter.
        send_word(ACT_REMOVE, '0, 1'b0);
        send_word(ACT_REMOVE, '1, 1'b1);
        send_word(ACT_REMOVE, 14'h2AAA, 1'b0);
    endtask

    task automatic test_smallest_policy();
        send_word(ACT_ADD, 14'h0000, 1'b1);
        send_word(ACT_ADD, 14'h3FFF, 1'b0);
        send_word(ACT_ADD, 14'h0005, 1'b0);
        send_word(ACT_ADD, 14'h0005, 1'b1);
        send_word(ACT_ADD, 14'h2AAA, 1'b0);
        send_word(ACT_ADD, 14'h1555, 1'b0);
        send_word(ACT_REMOVE, 14'h3FFF, 1'b1);
        send_word(ACT_REMOVE, 14'h1555, 1'b1);
        send_word(ACT_REMOVE, 14'h0000, 1'b0);
        send_word(ACT_REMOVE, 14'h2AAA, 1'b1);
        send_word(ACT_REMOVE, 14'h0001, 1'b1);
        send_word(ACT_REMOVE, 14'h0000, 1'b1);
        send_word(ACT_REMOVE, 14'h3FFF, 1'b1);
    endtask

    task automatic test_largest_policy();
        set_policy(POLICY_LARGEST);
        send_word(ACT_ADD, 14'h3FFF, 1'b0);
        send_word(ACT_ADD, 14'h0000, 1'b0);
        send_word(ACT_ADD, 14'h0064, 1'b0);
        send_word(ACT_REMOVE, 14'h0000, 1'b1);
        send_word(ACT_REMOVE, 14'h3FFF, 1'b1);
        send_word(ACT_REMOVE, 14'h1555, 1'b1);
        send_word(ACT_REMOVE, 14'h2AAA, 1'b1);
    endtask

    task automatic test_random_mix();
        int round_idx;
        int n;
        int base;
        int span;
        for (round_idx = 0; round_idx < ROUNDS; round_idx++)
        begin
            drain_queue();
            if (round_idx == ROUNDS - 1)
                base = NUM_KEYS - 256;
            else
                base = round_idx * 2300 + $urandom_range(0, 63);
            narrow_bounds(base);
            set_policy((round_idx % 2) ? POLICY_LARGEST : POLICY_SMALLEST);
            // One round runs with no gaps on either side.
            in_gaps_on = (round_idx != 2);
            out_gaps_on = (round_idx != 2);
            span = (round_idx % 3 == 0) ? 256 : ((round_idx % 3 == 1) ? 16 : 64);
            for (n = 0; n < ITEMS_PER_ROUND; n++)
            begin
                if ($urandom_range(99) < 55)
                    send_word(ACT_ADD, KEY_BITS'(base + int'($urandom_range(0, span - 1))),
                              1'($urandom_range(1)));
                else
                    send_word(ACT_REMOVE, KEY_BITS'($urandom_range(0, NUM_KEYS - 1)),
                              $urandom_range(99) < 75);
            end
        end
        in_gaps_on = 1'b1;
        out_gaps_on = 1'b1;
    endtask

    task automatic test_repeated_key();
        int deep_key;
        int tail_key;
        deep_key = NUM_KEYS - 200;
        tail_key = deep_key + 77;
        drain_queue();
        narrow_bounds(deep_key);
        set_policy(POLICY_SMALLEST);
        in_gaps_on = 1'b0;
        out_gaps_on = 1'b0;
        // Stack one key deep, then take exactly that many back out before the tail key.
        repeat (REPEAT_DEPTH)
            send_word(ACT_ADD, KEY_BITS'(deep_key), 1'($urandom_range(1)));
        send_word(ACT_ADD, KEY_BITS'(tail_key), 1'b0);
        repeat (REPEAT_DEPTH)
            send_word(ACT_REMOVE, KEY_BITS'($urandom_range(0, NUM_KEYS - 1)),
                      $urandom_range(3) == 0);
        send_word(ACT_REMOVE, KEY_BITS'($urandom_range(0, NUM_KEYS - 1)), 1'b1);
        send_word(ACT_REMOVE, KEY_BITS'($urandom_range(0, NUM_KEYS - 1)), 1'b1);
        in_gaps_on = 1'b1;
        out_gaps_on = 1'b1;
    endtask

    always @(negedge clk)
        out_stall <= out_gaps_on && ($urandom_range(99) < 28);

    task automatic log_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin : check_results
        removal_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (empty_res === 1'b1)
                empties_seen++;
            if (removals_due.size() == 0)
            begin
                log_mismatch($sformatf("unexpected word removed_key=%0d empty_res=%0b",
                                       removed_key, empty_res));
            end
            else
            begin
                want = removals_due.pop_front();
                if (removed_key !== want.key_out || empty_res !== want.empty_flag)
                    log_mismatch($sformatf(
                        "removed_key exp %0d got %0d, empty_res exp %0b got %0b",
                        want.key_out, removed_key, want.empty_flag, empty_res));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, removals_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        queue_reset();
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_at_reset();
        test_smallest_policy();
        test_largest_policy();
        test_random_mix();
        test_repeated_key();
        wait_quiet();

        $display("Sent %0d adds and %0d removes under both removal policies; %0d results checked,",
                 adds_sent, removes_sent, results_checked);
        $display("%0d of them empty; one key was stacked %0d deep and drained back out.",
                 empties_seen, REPEAT_DEPTH);
        if (mismatch_count == 0 && removals_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
src/cmmq_pkg.sv
src/cmmq_count_ram.sv
src/counting_min_max_queue.sv
tb/sv/tb_counting_min_max_queue.sv
